// ----- hdl/rxh_pkg.sv -----
`default_nettype none

package rxh_pkg;

   localparam int HASH_WIDTH  = 64;
   localparam int BYTE_WIDTH  = 8;
   localparam int SHIFT_WIDTH = 6;
   localparam int CSR_WIDTH   = 2;

   localparam logic [SHIFT_WIDTH-1:0] SHIFT_MASK = 6'h3F;
   localparam logic [SHIFT_WIDTH-1:0] HALF_TURN  = 6'd32;

   localparam logic                  COUNT_DOWN_RESET = 1'b0;
   localparam logic                  XOR_EN_RESET     = 1'b1;
   localparam logic [HASH_WIDTH-1:0] XOR_VALUE_RESET  = '0;

   typedef enum logic [CSR_WIDTH-1:0] {
      CSR_COUNT_DOWN_MODE  = 2'd0,
      CSR_FINAL_XOR_ENABLE = 2'd1,
      CSR_FINAL_XOR_VALUE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] length_low;
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  first_item;
      logic                  last_item;
      logic                  no_byte;
   } request_type;

endpackage

`default_nettype wire

// ----- hdl/rotate_xor_hash64.sv -----
// rotate_xor_hash64: streaming 64-bit rotate/XOR hash, one byte per request.
// Request channel (req_*): tdata carries data_byte and length_low, tuser
// carries first_item and no_byte, tlast marks the last request of a message.
// Response channel (rsp_*): one 64-bit hash per message, sent after the
// request marked tlast, final XOR applied when enabled.
// Configuration (csr_*): write-only, one register per cycle. The user must
// write them only while idle; the block itself does not enforce this.
// Throughput: one request per cycle while req_tready is high; the update is a
// single add, mask, 64-bit barrel rotate and XOR from input to hash register.
// Response: a tlast request waits in the input register, then its hash is
// loaded into the result register that drives rsp_tvalid.
// Stall: while a response waits on rsp_tready, requests that end no message
// still flow; a further tlast request waits in the input register and
// req_tready drops until the response is taken.
// Reset: clears the hash, the counter, all valid flags and the registers to
// count-up mode, final XOR enabled with value zero.
`default_nettype none

module rotate_xor_hash64 (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // data_byte[7:0], length_low[15:8]
   input  wire logic [1:0]  req_tuser,   // first_item[0], no_byte[1]
   input  wire logic        req_tlast,

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [63:0] rsp_tdata,   // hash_value[63:0]

   input  wire logic        csr_we,
   input  wire logic [rxh_pkg::CSR_WIDTH-1:0]  csr_index,
   input  wire logic [rxh_pkg::HASH_WIDTH-1:0] csr_wdata
);

   logic                              count_down_ff;
   logic                              xor_en_ff;
   logic [rxh_pkg::HASH_WIDTH-1:0]    xor_value_ff;

   rxh_pkg::request_type              req_ff, req_in;
   logic                              req_valid_ff, req_valid_in;

   logic [rxh_pkg::HASH_WIDTH-1:0]    hash_ff, hash_in;
   logic [rxh_pkg::BYTE_WIDTH-1:0]    count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rxh_pkg::HASH_WIDTH-1:0]    rsp_data_ff, rsp_data_in;

   logic                              advance;
   logic [rxh_pkg::HASH_WIDTH-1:0]    hash_base, hash_mix, hash_rot;
   logic [rxh_pkg::BYTE_WIDTH-1:0]    count_base, byte_sum;
   logic [rxh_pkg::SHIFT_WIDTH-1:0]   shift;
   logic [rxh_pkg::SHIFT_WIDTH:0]     back_shift;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         count_down_ff <= rxh_pkg::COUNT_DOWN_RESET;
         xor_en_ff     <= rxh_pkg::XOR_EN_RESET;
         xor_value_ff  <= rxh_pkg::XOR_VALUE_RESET;
      end else if (csr_we) begin
         unique case (rxh_pkg::csr_index_type'(csr_index))
            rxh_pkg::CSR_COUNT_DOWN_MODE:  count_down_ff <= csr_wdata[0];
            rxh_pkg::CSR_FINAL_XOR_ENABLE: xor_en_ff     <= csr_wdata[0];
            rxh_pkg::CSR_FINAL_XOR_VALUE:  xor_value_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a last request may only go ahead once the result register is free
   assign advance    = req_valid_ff &&
                       !(req_ff.last_item && rsp_valid_ff && !rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_in.data_byte  = req_tdata[7:0];
      req_in.length_low = req_tdata[15:8];
      req_in.first_item = req_tuser[0];
      req_in.no_byte    = req_tuser[1];
      req_in.last_item  = req_tlast;
      req_valid_in      = req_tready ? req_tvalid : req_valid_ff;
   end

   // hash update
   always_comb begin
      hash_base  = req_ff.first_item ? '0 : hash_ff;
      count_base = req_ff.first_item ?
                   (count_down_ff ? req_ff.length_low : '0) : count_ff;

      hash_mix   = hash_base ^ {{(rxh_pkg::HASH_WIDTH-rxh_pkg::BYTE_WIDTH){1'b0}},
                                req_ff.data_byte};
      byte_sum   = req_ff.data_byte + count_base;
      shift      = byte_sum[rxh_pkg::SHIFT_WIDTH-1:0] & rxh_pkg::SHIFT_MASK;
      back_shift = (rxh_pkg::SHIFT_WIDTH+1)'(rxh_pkg::HASH_WIDTH) -
                   {1'b0, shift};
      hash_rot   = (hash_mix << shift) | (hash_mix >> back_shift);

      hash_in  = hash_ff;
      count_in = count_ff;
      if (advance) begin
         hash_in  = hash_base;
         count_in = count_base;
         if (!req_ff.no_byte) begin
            if (shift == '0 || shift == rxh_pkg::HALF_TURN) begin
               hash_in = hash_mix;
            end else begin
               hash_in = hash_mix ^ hash_rot;
            end
            count_in = count_down_ff ? count_base - 8'd1 : count_base + 8'd1;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (advance && req_ff.last_item) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = xor_en_ff ? (hash_in ^ xor_value_ff) : hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hash_ff      <= '0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         req_ff <= req_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/rotate_xor_hash64_tb.sv -----
`timescale 1ns / 100ps

module rotate_xor_hash64_tb;

   localparam int NUM_DIRECTED    = 18;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 216;
   localparam int CYCLE_LIMIT     = 400000;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_item;
      logic        last_item;
      logic        no_byte;
      logic [7:0]  length_low;
      logic        pinned;
      logic [63:0] pinned_hash;
   } stim_row_type;

   // pinned rows carry a hash worked out by hand from the reset settings
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 64'h0},                  // empty message
      '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 64'h0},                  // zero byte absorbed
      '{8'h01, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 64'h3},
      '{8'h20, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 64'h20},                 // half turn skipped
      '{8'h40, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 64'h40},                 // shift masks to zero
      '{8'hFF, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 64'h8000_0000_0000_0080},
      '{8'hA5, 1'b1, 1'b0, 1'b0, 8'h03, 1'b0, 64'h0},
      '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 64'h0},
      '{8'h7E, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 64'h0},
      '{8'h12, 1'b1, 1'b0, 1'b0, 8'h02, 1'b0, 64'h0},
      '{8'hFF, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0, 64'h0},                 // no byte mid-message
      '{8'h34, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 64'h0},
      '{8'h56, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 64'h0},                 // extends last message
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 64'h0},
      '{8'h9C, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0, 64'h0},
      '{8'hC3, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 64'h0},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1, 64'h8000_0000_0000_0080},
      '{8'h11, 1'b1, 1'b0, 1'b0, 8'h05, 1'b0, 64'h0}                  // left open
   };

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [15:0]   req_tdata;   // data_byte[7:0], length_low[15:8]
   logic [1:0]    req_tuser;   // first_item[0], no_byte[1]
   logic          req_tlast;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [63:0]   rsp_tdata;   // hash_value[63:0]
   logic          csr_we;
   rxh_pkg::csr_index_type csr_index;
   logic [63:0]   csr_wdata;

   logic          pin_valid;
   logic [63:0]   pin_value;
   bit            calm;
   int            msg_left;
   int            cycle_count;
   int            error_count;
   int            requests_seen;
   int            hashes_checked;

   logic [63:0]   hash_state;
   logic [7:0]    count_state;
   logic          down_mirror;
   logic          xor_en_mirror;
   logic [63:0]   xor_val_mirror;
   logic [63:0]   expected_hash_q [$];

   rotate_xor_hash64 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic absorb_request(input logic [7:0] data_byte, input logic first_item,
                                 input logic last_item, input logic no_byte,
                                 input logic [7:0] length_low, input logic pinned,
                                 input logic [63:0] pinned_hash);
      logic [7:0] sum;
      logic [5:0] shift;
      if (first_item) begin
         hash_state  = '0;
         count_state = down_mirror ? length_low : 8'd0;
      end
      if (!no_byte) begin
         hash_state ^= {56'd0, data_byte};
         sum   = data_byte + count_state;
         shift = sum[5:0] & rxh_pkg::SHIFT_MASK;
         if (shift != 6'd0 && shift != rxh_pkg::HALF_TURN)
            hash_state ^= (hash_state << shift) |
                          (hash_state >> (rxh_pkg::HASH_WIDTH - shift));
         count_state = down_mirror ? count_state - 8'd1 : count_state + 8'd1;
      end
      if (last_item)
         expected_hash_q.push_back(pinned ? pinned_hash :
                                   (xor_en_mirror ? hash_state ^ xor_val_mirror : hash_state));
   endtask

   always @(posedge clock) begin
      logic [63:0] expected;
      if (reset) begin
         hash_state     = '0;
         count_state    = '0;
         down_mirror    = rxh_pkg::COUNT_DOWN_RESET;
         xor_en_mirror  = rxh_pkg::XOR_EN_RESET;
         xor_val_mirror = rxh_pkg::XOR_VALUE_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hash_q.size() == 0) begin
               $error("hash_value %h arrived with no request pending", rsp_tdata);
               error_count++;
            end else begin
               expected = expected_hash_q.pop_front();
               if (rsp_tdata !== expected) begin
                  $error("hash_value mismatch: expected %h, actual %h", expected, rsp_tdata);
                  error_count++;
               end
            end
            hashes_checked++;
         end
         if (req_tvalid && req_tready) begin
            absorb_request(req_tdata[7:0], req_tuser[0], req_tlast, req_tuser[1],
                           req_tdata[15:8], pin_valid, pin_value);
            requests_seen++;
         end
         if (csr_we) begin
            case (csr_index)
               rxh_pkg::CSR_COUNT_DOWN_MODE:  down_mirror    = csr_wdata[0];
               rxh_pkg::CSR_FINAL_XOR_ENABLE: xor_en_mirror  = csr_wdata[0];
               rxh_pkg::CSR_FINAL_XOR_VALUE:  xor_val_mirror = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // response side back-pressure
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   task automatic issue_request(input stim_row_type item);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {item.length_low, item.data_byte};
      req_tuser  <= {item.no_byte, item.first_item};
      req_tlast  <= item.last_item;
      pin_valid  <= item.pinned;
      pin_value  <= item.pinned_hash;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop valid, wait out every pending hash, then let the input stage empty
   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (expected_hash_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic program_settings(input logic mode, input logic xor_en,
                                   input logic [63:0] xor_val);
      csr_we    <= 1'b1;
      csr_index <= rxh_pkg::CSR_COUNT_DOWN_MODE;
      csr_wdata <= {63'd0, mode};
      @(negedge clock);
      csr_index <= rxh_pkg::CSR_FINAL_XOR_ENABLE;
      csr_wdata <= {63'd0, xor_en};
      @(negedge clock);
      csr_index <= rxh_pkg::CSR_FINAL_XOR_VALUE;
      csr_wdata <= xor_val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly whole messages with random bytes; some empty, some long enough to wrap
   task automatic run_random(input int quota);
      stim_row_type item;
      int           counted;
      int           pick;
      counted = 0;
      while (counted < quota) begin
         item            = '0;
         item.data_byte  = 8'($urandom);
         item.length_low = 8'($urandom);
         if (msg_left == 0) begin
            pick = $urandom_range(0, 49);
            item.first_item = 1'b1;
            if (pick < 3) begin
               item.no_byte   = 1'b1;
               item.last_item = 1'b1;
            end else begin
               msg_left = (pick == 3) ? $urandom_range(240, 300) : $urandom_range(1, 16);
               if ($urandom_range(0, 7) != 0)
                  item.length_low = 8'(msg_left);
            end
         end
         if (msg_left != 0) begin
            item.last_item = (msg_left == 1);
            msg_left--;
         end
         if ($urandom_range(0, 9) == 0) begin
            {item.no_byte, item.last_item, item.first_item} = 3'($urandom);
            if (item.last_item)
               msg_left = 0;
         end
         issue_request(item);
         if (!(item.no_byte && !item.first_item && !item.last_item))
            counted++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      req_tlast      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = rxh_pkg::CSR_COUNT_DOWN_MODE;
      csr_wdata      = '0;
      pin_valid      = 1'b0;
      pin_value      = '0;
      calm           = 1'b0;
      msg_left       = 0;
      cycle_count    = 0;
      error_count    = 0;
      requests_seen  = 0;
      hashes_checked = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         issue_request(DIRECTED_ROWS[i]);
      msg_left = 4;
      drain_requests();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: program_settings(1'b1, 1'b1, '1);
            1: program_settings(1'b0, 1'b0, '0);
            2: program_settings(1'b1, 1'b1, '0);
            3: program_settings(1'b1, 1'b1, 64'h8000_0000_0000_0001);
            4: program_settings(1'b0, 1'b1, '1);
            default: program_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      {$urandom, $urandom});
         endcase
         calm = (p == NUM_PHASES - 1);
         run_random(ITEMS_PER_PHASE);
         drain_requests();
      end
      repeat (8) @(negedge clock);

      $display("Run covered %0d requests and %0d hash responses over %0d register settings,",
               requests_seen, hashes_checked, NUM_PHASES + 1);
      $display("with both counter directions, final XOR on and off, empty and wrapping messages.");
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/rxh_pkg.sv
hdl/rotate_xor_hash64.sv
tb/rotate_xor_hash64_tb.sv
